[src/tcon_pkg.sv]
// ----------------------------------------------------------------------------
// tcon_pkg
// Shared constants for the text console: screen geometry, field widths,
// request codes and character codes.
// ----------------------------------------------------------------------------
package tcon_pkg;

  // screen geometry
  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  // field widths
  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE   = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE       = 8'h20;
  localparam logic [CHAR_W-1:0] CH_FIRST_PRINT = 8'd32;
  localparam logic [CHAR_W-1:0] CH_LAST_PRINT  = 8'd126;

endpackage

[src/tcon_ram.sv]
// ----------------------------------------------------------------------------
// tcon_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module tcon_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/text_console_char_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// 25 x 80 text screen with cursor: writes characters, reads cells, clears.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers at a clock edge with start high and busy low. Each
//   request gives one result, shown for a single cycle with done high; the
//   receiver must take it then, it cannot stall the block.
//   Rows are kept in a circular order in one single-port cell RAM, so a
//   scroll only moves the top-row pointer and blanks one row.
//   Each request runs through these sequencer states. Every access goes
//   through the one RAM port, and all but the clear sweep through the one
//   address unit (row * COLS + column):
//     write without scroll, unknown request, read out of range: S_EXEC
//     read in range: S_EXEC, then S_READ for the registered read
//     newline on the bottom row (scroll): S_EXEC, then S_BLANK on one row
//     clear screen: S_EXEC, then S_CLEAR over all ROWS * COLS cells
//   busy stays high from the transfer until the cycle of done; the next
//   request may transfer in the done cycle, so requests never overlap.
//   After reset the block sweeps the whole RAM to spaces, one cell a cycle,
//   with busy high and no result.
// ----------------------------------------------------------------------------
module text_console_char_writer_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tcon_pkg::REQ_W-1:0]   req_type,
  input  logic [tcon_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcon_pkg::ROW_W-1:0]   read_row,
  input  logic [tcon_pkg::COL_W-1:0]   read_col,
  output logic                         busy,
  output logic                         done,
  output logic [tcon_pkg::CHAR_W-1:0]  cell_char,
  output logic [tcon_pkg::ROW_W-1:0]   cursor_row_out,
  output logic [tcon_pkg::COL_W-1:0]   cursor_col_out,
  output logic                         scrolled
);

  localparam int ROW_W  = tcon_pkg::ROW_W;
  localparam int COL_W  = tcon_pkg::COL_W;
  localparam int ADDR_W = tcon_pkg::ADDR_W;

  localparam logic [ROW_W:0]    ROWS_X   = (ROW_W+1)'(tcon_pkg::ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(tcon_pkg::ROWS - 1);
  localparam logic [COL_W:0]    COLS_X   = (COL_W+1)'(tcon_pkg::COLS);
  localparam logic [COL_W-1:0]  COLS_C   = COL_W'(tcon_pkg::COLS);
  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(tcon_pkg::COLS);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(tcon_pkg::CELLS - 1);
  localparam logic [ADDR_W-1:0] COL_LAST_A = ADDR_W'(tcon_pkg::COLS - 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_BLANK = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0] state, state_next;

  // cursor and row pointer
  logic [ROW_W-1:0] line, line_next;
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] base, base_next;
  logic [ROW_W-1:0] blank_row, blank_row_next;
  logic [ADDR_W-1:0] sweep, sweep_next;
  logic respond, respond_next;

  // latched request
  logic [tcon_pkg::REQ_W-1:0]  req_q;
  logic [tcon_pkg::CHAR_W-1:0] code_q;
  logic [ROW_W-1:0]            row_q;
  logic [COL_W-1:0]            col_q;

  // result registers
  logic                        done_next;
  logic [tcon_pkg::CHAR_W-1:0] cell_char_next;
  logic [ROW_W-1:0]            cursor_row_out_next;
  logic [COL_W-1:0]            cursor_col_out_next;
  logic                        scrolled_next;

  // address unit and ram port
  logic [ROW_W-1:0]            log_row, phys_row, unit_row, base_inc;
  logic [ROW_W:0]              phys_sum;
  logic [COL_W-1:0]            unit_col;
  logic [ADDR_W-1:0]           unit_addr, ram_addr;
  logic                        ram_we;
  logic [tcon_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

  logic is_read, is_bs, is_print, read_ok;

  assign busy = (state != S_IDLE);

  // request decode
  assign is_read  = (req_q == tcon_pkg::REQ_READ);
  assign is_bs    = (code_q == tcon_pkg::CH_BACKSPACE);
  assign is_print = (code_q >= tcon_pkg::CH_FIRST_PRINT) &&
                    (code_q <= tcon_pkg::CH_LAST_PRINT);
  assign read_ok  = ({1'b0, row_q} < ROWS_X) && ({1'b0, col_q} < COLS_X);

  // logical to physical row through the circular top-row pointer
  assign log_row  = (state == S_EXEC && is_read) ? row_q : line;
  assign phys_sum = {1'b0, log_row} + {1'b0, base};
  assign phys_row = (phys_sum >= ROWS_X) ? ROW_W'(phys_sum - ROWS_X) : phys_sum[ROW_W-1:0];
  assign base_inc = (base == ROW_LAST) ? '0 : base + 1'b1;

  // shared address unit: row * COLS + column
  always_comb begin
    unit_row = phys_row;
    unit_col = col;
    if (state == S_BLANK) begin
      unit_row = blank_row;
      unit_col = sweep[COL_W-1:0];
    end else if (is_read) begin
      unit_col = col_q;
    end else if (is_bs) begin
      unit_col = col - 1'b1;
    end
  end

  assign unit_addr = ADDR_W'(unit_row) * COLS_A + ADDR_W'(unit_col);
  assign ram_addr  = (state == S_CLEAR) ? sweep : unit_addr;

  // sequencer
  always_comb begin
    state_next          = state;
    line_next           = line;
    col_next            = col;
    base_next           = base;
    blank_row_next      = blank_row;
    sweep_next          = sweep;
    respond_next        = respond;
    done_next           = 1'b0;
    cell_char_next      = '0;
    cursor_row_out_next = cursor_row_out;
    cursor_col_out_next = cursor_col_out;
    scrolled_next       = 1'b0;
    ram_we              = 1'b0;
    ram_wdata           = tcon_pkg::CH_SPACE;

    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (sweep == CELL_LAST) begin
          state_next          = S_IDLE;
          done_next           = respond;
          respond_next        = 1'b0;
          cursor_row_out_next = line;
          cursor_col_out_next = col;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        case (req_q)
          tcon_pkg::REQ_WRITE: begin
            if (code_q == tcon_pkg::CH_NEWLINE) begin
              col_next = '0;
              if (line == ROW_LAST) begin
                // scroll: old top row becomes the blank bottom row
                blank_row_next = base;
                base_next      = base_inc;
                sweep_next     = '0;
                state_next     = S_BLANK;
                done_next      = 1'b0;
              end else begin
                line_next = line + 1'b1;
              end
            end else if (is_bs) begin
              if (col != '0) begin
                ram_we   = 1'b1;
                col_next = col - 1'b1;
              end
            end else if (is_print && col < COLS_C) begin
              ram_we    = 1'b1;
              ram_wdata = code_q;
              col_next  = col + 1'b1;
            end
          end
          tcon_pkg::REQ_READ: begin
            if (read_ok) begin
              state_next = S_READ;
              done_next  = 1'b0;
            end
          end
          tcon_pkg::REQ_CLEAR: begin
            line_next    = '0;
            col_next     = '0;
            base_next    = '0;
            sweep_next   = '0;
            respond_next = 1'b1;
            state_next   = S_CLEAR;
            done_next    = 1'b0;
          end
          default: begin
          end
        endcase
        cursor_row_out_next = line_next;
        cursor_col_out_next = col_next;
      end
      S_BLANK: begin
        ram_we = 1'b1;
        if (sweep == COL_LAST_A) begin
          state_next          = S_IDLE;
          done_next           = 1'b1;
          scrolled_next       = 1'b1;
          cursor_row_out_next = line;
          cursor_col_out_next = col;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      S_READ: begin
        state_next          = S_IDLE;
        done_next           = 1'b1;
        cell_char_next      = ram_rdata;
        cursor_row_out_next = line;
        cursor_col_out_next = col;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      line    <= '0;
      col     <= '0;
      base    <= '0;
      sweep   <= '0;
      respond <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      line    <= line_next;
      col     <= col_next;
      base    <= base_next;
      sweep   <= sweep_next;
      respond <= respond_next;
      done    <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    blank_row      <= blank_row_next;
    cell_char      <= cell_char_next;
    cursor_row_out <= cursor_row_out_next;
    cursor_col_out <= cursor_col_out_next;
    scrolled       <= scrolled_next;
    if (start && !busy) begin
      req_q  <= req_type;
      code_q <= char_code;
      row_q  <= read_row;
      col_q  <= read_col;
    end
  end

  // cell memory
  tcon_ram #(
    .WIDTH(tcon_pkg::CHAR_W),
    .DEPTH(tcon_pkg::CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("transfer did not start the sequencer");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, line} < ROWS_X) && ({1'b0, col} <= COLS_X) && ({1'b0, base} < ROWS_X))
    else $error("cursor or row pointer out of range");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    done && scrolled |-> (cursor_row_out == ROW_LAST) && (cursor_col_out == '0))
    else $error("scroll left the cursor off the bottom row start");

  a_blank_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_BLANK || state == S_CLEAR) |-> ram_we && (ram_wdata == tcon_pkg::CH_SPACE))
    else $error("sweep not writing spaces");

endmodule
